FILE: hw/rtl/itsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itsm_pkg: trip tracker shared types and codes
// Input kinds, report codes, trip states, register indexes and structs.
// ----------------------------------------------------------------------------
package itsm_pkg;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    FUNC_RPM   = 2'd0,
    FUNC_SPEED = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REP_IGN_ON   = 3'd0,
    REP_IGN_OFF  = 3'd1,
    REP_START    = 3'd2,
    REP_STOP     = 3'd3,
    REP_PERIODIC = 3'd4
  } report_t;

  localparam logic [1:0] TRIP_IDLE    = 2'd0;
  localparam logic [1:0] TRIP_IGN_ON  = 2'd1;
  localparam logic [1:0] TRIP_MOVING  = 2'd2;
  localparam logic [1:0] TRIP_STOPPED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_QUAL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_PER   = 3'd5;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_IGN_ON  = 4'b0010,
    MODE_MOVING  = 4'b0100,
    MODE_STOPPED = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [9:0]  launch_speed;
    logic [15:0] start_time;
    logic [15:0] rpm_qualify_time;
    logic [9:0]  stop_speed;
    logic [15:0] stop_time;
    logic [23:0] report_period;
  } itsm_cfg_t;

  typedef struct packed {
    logic [2:0] report_code;
    logic [1:0] trip_state;
  } itsm_result_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    case (m)
      MODE_IDLE:    c = TRIP_IDLE;
      MODE_IGN_ON:  c = TRIP_IGN_ON;
      MODE_MOVING:  c = TRIP_MOVING;
      MODE_STOPPED: c = TRIP_STOPPED;
      default:      c = TRIP_IDLE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/itsm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itsm_if: trip tracker channels
// Sample channel (rpm, speed, tick) and report channel, valid/ready.
// ----------------------------------------------------------------------------
interface itsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [13:0] rpm_value;
  logic [9:0]  speed_value;

  modport source (output valid, func, rpm_value, speed_value, input ready);
  modport sink (input valid, func, rpm_value, speed_value, output ready);
endinterface

interface itsm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] report_code;
  logic [1:0] trip_state;

  modport source (output valid, report_code, trip_state, input ready);
  modport sink (input valid, report_code, trip_state, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/itsm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itsm_cfg_regs: configuration registers
// Write-only register file for thresholds, qualify times and report period.
// ----------------------------------------------------------------------------
module itsm_cfg_regs
  import itsm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
  output itsm_cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.launch_speed     <= 10'd10;
      cfg.start_time       <= 16'd5000;
      cfg.rpm_qualify_time <= 16'd3000;
      cfg.stop_speed       <= 10'd5;
      cfg.stop_time        <= 16'd60000;
      cfg.report_period    <= 24'd60000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LAUNCH_SPEED: cfg.launch_speed     <= cfg_wr_data[9:0];
        REG_START_TIME:   cfg.start_time       <= cfg_wr_data[15:0];
        REG_RPM_QUAL:     cfg.rpm_qualify_time <= cfg_wr_data[15:0];
        REG_STOP_SPEED:   cfg.stop_speed       <= cfg_wr_data[9:0];
        REG_STOP_TIME:    cfg.stop_time        <= cfg_wr_data[15:0];
        REG_REPORT_PER:   cfg.report_period    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/itsm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itsm_core: trip state and countdowns
// One-pass update of mode, qualification and timers per accepted word.
// ----------------------------------------------------------------------------
module itsm_core
  import itsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire itsm_cfg_t   cfg,
  input  wire logic        accept,
  input  wire logic [1:0]  func,
  input  wire logic [13:0] rpm_value,
  input  wire logic [9:0]  speed_value,
  output logic             push,
  output itsm_result_t     res
);

  mode_t       mode, mode_next;
  logic        qualifying, qualifying_next;
  logic [15:0] rpm_countdown, rpm_countdown_next;
  logic [15:0] speed_countdown, speed_countdown_next;
  logic [23:0] report_countdown, report_countdown_next;
  logic        report_running, report_running_next;

  logic        q_act, q_cond, q_speed, fire;
  logic [15:0] q_load, q_cnt;
  logic [2:0]  code;

  always_comb begin
    q_act   = 1'b0;
    q_cond  = 1'b0;
    q_speed = 1'b0;
    q_load  = cfg.rpm_qualify_time;
    case (func_t'(func))
      FUNC_RPM: begin
        if (mode == MODE_IDLE) begin
          q_act  = 1'b1;
          q_cond = (rpm_value != 14'd0);
        end else if (mode == MODE_IGN_ON || mode == MODE_STOPPED) begin
          q_act  = 1'b1;
          q_cond = (rpm_value == 14'd0);
        end
      end
      FUNC_SPEED: begin
        q_speed = 1'b1;
        if (mode == MODE_IGN_ON || mode == MODE_STOPPED) begin
          q_act  = 1'b1;
          q_cond = (speed_value > cfg.launch_speed);
          q_load = cfg.start_time;
        end else if (mode == MODE_MOVING) begin
          q_act  = 1'b1;
          q_cond = (speed_value < cfg.stop_speed);
          q_load = cfg.stop_time;
        end
      end
      default: ;
    endcase
  end

  assign q_cnt = q_speed ? speed_countdown : rpm_countdown;

  always_comb begin
    mode_next             = mode;
    qualifying_next       = qualifying;
    rpm_countdown_next    = rpm_countdown;
    speed_countdown_next  = speed_countdown;
    report_countdown_next = report_countdown;
    report_running_next   = report_running;
    fire                  = 1'b0;
    push                  = 1'b0;
    code                  = REP_IGN_ON;

    if (func_t'(func) == FUNC_TICK) begin
      if (rpm_countdown != 16'd0) rpm_countdown_next = rpm_countdown - 16'd1;
      if (speed_countdown != 16'd0) speed_countdown_next = speed_countdown - 16'd1;
      if (report_running) begin
        if (report_countdown <= 24'd1) begin
          report_countdown_next = cfg.report_period;
          code = REP_PERIODIC;
          push = accept;
        end else begin
          report_countdown_next = report_countdown - 24'd1;
        end
      end
    end else if (q_act) begin
      if (q_cond) begin
        if (!qualifying) begin
          qualifying_next = 1'b1;
          if (q_speed) speed_countdown_next = q_load;
          else rpm_countdown_next = q_load;
        end else if (q_cnt == 16'd0) begin
          qualifying_next = 1'b0;
          fire = 1'b1;
        end
      end else begin
        qualifying_next = 1'b0;
        if (q_speed) speed_countdown_next = 16'd0;
        else rpm_countdown_next = 16'd0;
      end
    end

    if (fire) begin
      push = accept;
      if (!q_speed) begin
        if (mode == MODE_IDLE) begin
          mode_next = MODE_IGN_ON;
          code      = REP_IGN_ON;
        end else begin
          mode_next = MODE_IDLE;
          code      = REP_IGN_OFF;
        end
      end else if (mode == MODE_MOVING) begin
        mode_next           = MODE_STOPPED;
        code                = REP_STOP;
        report_running_next = 1'b0;
      end else begin
        mode_next             = MODE_MOVING;
        code                  = REP_START;
        report_running_next   = 1'b1;
        report_countdown_next = cfg.report_period;
      end
    end

    res.report_code = code;
    res.trip_state  = mode_code(mode_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_IDLE;
      qualifying       <= 1'b0;
      rpm_countdown    <= 16'd0;
      speed_countdown  <= 16'd0;
      report_countdown <= 24'd0;
      report_running   <= 1'b0;
    end else if (accept) begin
      mode             <= mode_next;
      qualifying       <= qualifying_next;
      rpm_countdown    <= rpm_countdown_next;
      speed_countdown  <= speed_countdown_next;
      report_countdown <= report_countdown_next;
      report_running   <= report_running_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/itsm_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itsm_out_buf: report output register with skid stage
// Holds up to two report words so the sample side keeps running.
// ----------------------------------------------------------------------------
module itsm_out_buf
  import itsm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire itsm_result_t res,
  output logic              space,
  itsm_out_if.source        result
);

  logic         main_valid;
  itsm_result_t main_data;
  logic         skid_valid;
  itsm_result_t skid_data;
  logic         out_fire;

  assign out_fire           = main_valid && result.ready;
  assign space              = !skid_valid;
  assign result.valid       = main_valid;
  assign result.report_code = main_data.report_code;
  assign result.trip_state  = main_data.trip_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || out_fire) begin
        main_data  <= res;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      main_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ignition_trip_state_machine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ignition_trip_state_machine: vehicle trip tracker
// Tracks idle / ignition on / moving / stopped from rpm, speed and ms ticks.
//
// Usage:
//   item   - sample words: func selects rpm sample, speed sample or 1 ms tick.
//   result - report words (report code, trip state after the change);
//            a word produces at most one report.
//   cfg_*  - write-only registers (thresholds, qualify times, report
//            period); write only while the block is idle.
// Timing: one word accepted per cycle while item.ready is high. A report
//   is registered into the output register, or into the skid entry if
//   that is still full. State update is a single registered pass per word.
// Stall: a two-entry output stage (register plus skid) absorbs reports;
//   item.ready drops only while both entries are full.
// Reset: rst (synchronous) returns to idle with all countdowns cleared,
//   registers at their defaults and the output stage empty.
// ----------------------------------------------------------------------------
module ignition_trip_state_machine
  import itsm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  itsm_in_if.sink                    item,
  itsm_out_if.source                 result,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

  itsm_cfg_t    cfg;
  itsm_result_t res;
  logic         push;
  logic         space;
  logic         accept;

  assign item.ready = space;
  assign accept     = item.valid && space;

  itsm_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  itsm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .func        (item.func),
    .rpm_value   (item.rpm_value),
    .speed_value (item.speed_value),
    .push        (push),
    .res         (res)
  );

  itsm_out_buf u_out (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .res    (res),
    .space  (space),
    .result (result)
  );

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> result.valid)
    else $error("skid full while output register empty");

  a_start_is_moving: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.report_code == REP_START) |-> result.trip_state == TRIP_MOVING)
    else $error("start report without moving state");

  a_off_is_idle: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.report_code == REP_IGN_OFF) |-> result.trip_state == TRIP_IDLE)
    else $error("ignition off report without idle state");

  a_no_push_when_idle: assert property (@(posedge clk) disable iff (rst)
    push |-> accept)
    else $error("report pushed without accepted word");
`endif

endmodule
`default_nettype wire
